>>> rtl/rgb_color_match_classifier_unit_assert.svh
// ----------------------------------------------------------------------------
// rgb color match classifier assertion macros
// shared property templates for the classifier rtl
// ----------------------------------------------------------------------------
`ifndef RGB_COLOR_MATCH_CLASSIFIER_UNIT_ASSERT_SVH
`define RGB_COLOR_MATCH_CLASSIFIER_UNIT_ASSERT_SVH

// condition in this cycle implies consequence in the same cycle
`define RCM_ASSERT_SAME(label, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error("rcm same-cycle check failed");

// condition in this cycle implies consequence in the next cycle
`define RCM_ASSERT_NEXT(label, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error("rcm next-cycle check failed");

`endif

>>> rtl/rcm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcm_pkg
// types, codes and mapping constants of the rgb color match classifier
// ----------------------------------------------------------------------------
package rcm_pkg;

    typedef enum logic [3:0] {
        PH_RED   = 4'b0001,
        PH_GREEN = 4'b0010,
        PH_BLUE  = 4'b0100,
        PH_CALC  = 4'b1000
    } phase_t;

    localparam logic [1:0] PHASE_CODE_RED   = 2'd0;
    localparam logic [1:0] PHASE_CODE_GREEN = 2'd1;
    localparam logic [1:0] PHASE_CODE_BLUE  = 2'd2;
    localparam logic [1:0] PHASE_CODE_CALC  = 2'd3;

    // filter select, bit1 s2 bit0 s3
    localparam logic [1:0] FILTER_RED   = 2'd0;
    localparam logic [1:0] FILTER_GREEN = 2'd3;
    localparam logic [1:0] FILTER_BLUE  = 2'd1;

    localparam logic CMD_ADVANCE = 1'b0;
    localparam logic CMD_CLEAR   = 1'b1;

    localparam logic [2:0] CFG_FOOD_COLOR      = 3'd0;
    localparam logic [2:0] CFG_POISON_COLOR    = 3'd1;
    localparam logic [2:0] CFG_RED_TOLERANCE   = 3'd2;
    localparam logic [2:0] CFG_GREEN_TOLERANCE = 3'd3;
    localparam logic [2:0] CFG_BLUE_TOLERANCE  = 3'd4;

    // pulse width ranges per channel: short end maps to full scale
    localparam int RED_LO_I   = 6;
    localparam int RED_HI_I   = 62;
    localparam int GREEN_LO_I = 6;
    localparam int GREEN_HI_I = 70;
    localparam int BLUE_LO_I  = 1;
    localparam int BLUE_HI_I  = 20;
    localparam int FULL_SCALE = 255;

    // scaled reciprocals of the span, rounded up; exact for all offsets below the span
    localparam int LEVEL_SHIFT   = 12;
    localparam int RED_RECIP_I   = ((1 << LEVEL_SHIFT) * FULL_SCALE + (RED_HI_I - RED_LO_I) - 1)
                                   / (RED_HI_I - RED_LO_I);
    localparam int GREEN_RECIP_I = ((1 << LEVEL_SHIFT) * FULL_SCALE
                                   + (GREEN_HI_I - GREEN_LO_I) - 1) / (GREEN_HI_I - GREEN_LO_I);
    localparam int BLUE_RECIP_I  = ((1 << LEVEL_SHIFT) * FULL_SCALE
                                   + (BLUE_HI_I - BLUE_LO_I) - 1) / (BLUE_HI_I - BLUE_LO_I);

    localparam int RECIP_W  = 16;
    localparam int OFFSET_W = 6;
    localparam int PROD_W   = RECIP_W + OFFSET_W;

    localparam logic [7:0] RED_LO   = 8'(RED_LO_I);
    localparam logic [7:0] RED_HI   = 8'(RED_HI_I);
    localparam logic [7:0] GREEN_LO = 8'(GREEN_LO_I);
    localparam logic [7:0] GREEN_HI = 8'(GREEN_HI_I);
    localparam logic [7:0] BLUE_LO  = 8'(BLUE_LO_I);
    localparam logic [7:0] BLUE_HI  = 8'(BLUE_HI_I);
    localparam logic [RECIP_W-1:0] RED_RECIP   = RECIP_W'(RED_RECIP_I);
    localparam logic [RECIP_W-1:0] GREEN_RECIP = RECIP_W'(GREEN_RECIP_I);
    localparam logic [RECIP_W-1:0] BLUE_RECIP  = RECIP_W'(BLUE_RECIP_I);
    localparam logic [7:0] LEVEL_MAX = 8'(FULL_SCALE);

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } rgb_t;

    typedef struct packed {
        phase_t     phase;
        logic [7:0] width;
    } lvl_req_t;

    function automatic logic [1:0] phase_code(input phase_t ph);
        logic [1:0] code;
        unique case (ph)
            PH_RED:   code = PHASE_CODE_RED;
            PH_GREEN: code = PHASE_CODE_GREEN;
            PH_BLUE:  code = PHASE_CODE_BLUE;
            PH_CALC:  code = PHASE_CODE_CALC;
            default:  code = PHASE_CODE_RED;
        endcase
        return code;
    endfunction

    function automatic logic [1:0] filter_of(input phase_t ph);
        logic [1:0] sel;
        unique case (ph)
            PH_GREEN: sel = FILTER_GREEN;
            PH_BLUE:  sel = FILTER_BLUE;
            default:  sel = FILTER_RED;
        endcase
        return sel;
    endfunction

endpackage

>>> rtl/rcm_level_map.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcm_level_map
// maps a measured pulse width onto a 0..255 level for the active channel
// ----------------------------------------------------------------------------
module rcm_level_map (
    input  rcm_pkg::lvl_req_t req,
    output logic [7:0]        level
);
    import rcm_pkg::*;

    logic [7:0]          lo;
    logic [7:0]          hi;
    logic [RECIP_W-1:0]  recip;
    logic [7:0]          offset_full;
    logic [OFFSET_W-1:0] offset;
    logic [PROD_W-1:0]   prod;
    logic [7:0]          quot;

    always_comb
    begin
        unique case (req.phase)
            PH_GREEN:
            begin
                lo    = GREEN_LO;
                hi    = GREEN_HI;
                recip = GREEN_RECIP;
            end
            PH_BLUE:
            begin
                lo    = BLUE_LO;
                hi    = BLUE_HI;
                recip = BLUE_RECIP;
            end
            default:
            begin
                lo    = RED_LO;
                hi    = RED_HI;
                recip = RED_RECIP;
            end
        endcase
    end

    // offset stays below the span inside the range, so it fits in six bits
    assign offset_full = req.width - lo;
    assign offset      = offset_full[OFFSET_W-1:0];
    assign prod        = PROD_W'(offset) * PROD_W'(recip);
    assign quot        = prod[LEVEL_SHIFT +: 8];

    always_comb
    begin
        priority if (req.width == 8'd0)
            level = 8'd0;
        else if (req.width <= lo)
            level = LEVEL_MAX;
        else if (req.width >= hi)
            level = 8'd0;
        else
            level = LEVEL_MAX - quot;
    end

endmodule

>>> rtl/rcm_window_match.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcm_window_match
// tests all three stored levels against a reference color within tolerance
// ----------------------------------------------------------------------------
module rcm_window_match (
    input  logic [23:0]   ref_color,
    input  rcm_pkg::rgb_t levels,
    input  rcm_pkg::rgb_t tols,
    output logic          hit
);
    import rcm_pkg::*;

    rgb_t ref_rgb;

    function automatic logic near(input logic [7:0] lvl, input logic [7:0] ref_v,
                                  input logic [7:0] tol);
        logic [8:0] lvl_up;
        logic [8:0] ref_up;
        lvl_up = {1'b0, lvl} + {1'b0, tol};
        ref_up = {1'b0, ref_v} + {1'b0, tol};
        return (lvl_up >= {1'b0, ref_v}) && ({1'b0, lvl} <= ref_up);
    endfunction

    assign ref_rgb = ref_color;
    assign hit = near(levels.red, ref_rgb.red, tols.red)
              && near(levels.green, ref_rgb.green, tols.green)
              && near(levels.blue, ref_rgb.blue, tols.blue);

endmodule

>>> rtl/rgb_color_match_classifier_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_color_match_classifier_unit
// four-phase color sensor sequencer with food and poison color matching
// ----------------------------------------------------------------------------
// usage
// - s_* stream: one transaction per sensor step; tuser is the command
//   (advance or clear flags), tdata the measured pulse width
// - m_* stream: one transaction per input transaction with the phase handled,
//   the next filter select, the three stored levels and both sticky flags
// - cfg_*: write enable, register index and data; write only while idle
// - an input transaction passes the input register, then the result register
// - throughput: one transaction per cycle while m_tready is high; the state
//   update of one item feeds the next through the combinational level map
//   and window compare
// - reset clears phase to red, all levels, flags and config registers
// - when m_tready is low the result register holds and the input register
//   still takes one more transaction before s_tready drops
// ----------------------------------------------------------------------------
module rgb_color_match_classifier_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // pulse_width[7:0]
    input  logic        s_tuser,   // command[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    // phase_done[1:0], next_filter[3:2], red_level[11:4], green_level[19:12],
    // blue_level[27:20], food_flag[28], poison_flag[29], zero pad[31:30]
    output logic [31:0] m_tdata,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [23:0] cfg_data
);
    import rcm_pkg::*;

    logic [23:0] food_color_reg;
    logic [23:0] poison_color_reg;
    rgb_t        tol_reg;

    logic        in_valid_reg;
    logic        in_cmd_reg;
    logic [7:0]  in_width_reg;

    phase_t      phase_reg;
    phase_t      phase_next;
    rgb_t        level_reg;
    rgb_t        level_next;
    logic        food_seen_reg;
    logic        food_seen_next;
    logic        poison_seen_reg;
    logic        poison_seen_next;

    logic        out_valid_reg;
    logic [31:0] out_data_reg;
    logic [31:0] out_data_next;

    logic        advance;
    lvl_req_t    lvl_req;
    logic [7:0]  mapped_level;
    logic        poison_hit;
    logic        food_hit;
    logic        poison_after;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            food_color_reg   <= '0;
            poison_color_reg <= '0;
            tol_reg          <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_FOOD_COLOR:      food_color_reg   <= cfg_data;
                CFG_POISON_COLOR:    poison_color_reg <= cfg_data;
                CFG_RED_TOLERANCE:   tol_reg.red      <= cfg_data[7:0];
                CFG_GREEN_TOLERANCE: tol_reg.green    <= cfg_data[7:0];
                CFG_BLUE_TOLERANCE:  tol_reg.blue     <= cfg_data[7:0];
                default:             ;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tvalid && s_tready)
            in_valid_reg <= 1'b1;
        else if (advance)
            in_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_cmd_reg   <= s_tuser;
            in_width_reg <= s_tdata;
        end
    end

    assign lvl_req.phase = phase_reg;
    assign lvl_req.width = in_width_reg;

    rcm_level_map u_level_map (
        .req   (lvl_req),
        .level (mapped_level)
    );

    rcm_window_match u_poison_match (
        .ref_color (poison_color_reg),
        .levels    (level_reg),
        .tols      (tol_reg),
        .hit       (poison_hit)
    );

    rcm_window_match u_food_match (
        .ref_color (food_color_reg),
        .levels    (level_reg),
        .tols      (tol_reg),
        .hit       (food_hit)
    );

    assign poison_after = poison_hit || poison_seen_reg;

    always_comb
    begin
        phase_next       = phase_reg;
        level_next       = level_reg;
        food_seen_next   = food_seen_reg;
        poison_seen_next = poison_seen_reg;
        if (advance)
        begin
            if (in_cmd_reg == CMD_CLEAR)
            begin
                food_seen_next   = 1'b0;
                poison_seen_next = 1'b0;
            end
            else
            begin
                unique case (phase_reg)
                    PH_RED:
                    begin
                        level_next.red = mapped_level;
                        phase_next     = PH_GREEN;
                    end
                    PH_GREEN:
                    begin
                        level_next.green = mapped_level;
                        phase_next       = PH_BLUE;
                    end
                    PH_BLUE:
                    begin
                        level_next.blue = mapped_level;
                        phase_next      = PH_CALC;
                    end
                    default:
                    begin
                        // poison wins; food only checked while poison stays clear
                        if (poison_hit)
                        begin
                            food_seen_next   = 1'b0;
                            poison_seen_next = 1'b1;
                        end
                        if (!poison_after && food_hit)
                        begin
                            food_seen_next   = 1'b1;
                            poison_seen_next = 1'b0;
                        end
                        phase_next = PH_RED;
                    end
                endcase
            end
        end
    end

    assign out_data_next = {2'b00, poison_seen_next, food_seen_next, level_next.blue,
                            level_next.green, level_next.red, filter_of(phase_next),
                            phase_code(phase_reg)};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_RED;
            level_reg       <= '0;
            food_seen_reg   <= 1'b0;
            poison_seen_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            phase_reg       <= phase_next;
            level_reg       <= level_next;
            food_seen_reg   <= food_seen_next;
            poison_seen_reg <= poison_seen_next;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            out_data_reg <= out_data_next;
    end

`include "rgb_color_match_classifier_unit_assert.svh"

    `RCM_ASSERT_SAME(a_flags_exclusive, 1'b1, !(food_seen_reg && poison_seen_reg))
    `RCM_ASSERT_NEXT(a_phase_holds_when_idle, !advance, $stable(phase_reg))
    `RCM_ASSERT_NEXT(a_clear_drops_flags, advance && (in_cmd_reg == CMD_CLEAR),
                     !food_seen_reg && !poison_seen_reg)
    `RCM_ASSERT_SAME(a_stall_only_when_full, !s_tready,
                     in_valid_reg && out_valid_reg && !m_tready)

endmodule
